// ===== sv/crystal_ball_exp_tail_pdf_assert.svh =====
// Assertion macros used by the block's top module.
`ifndef CRYSTAL_BALL_EXP_TAIL_PDF_ASSERT_SVH
`define CRYSTAL_BALL_EXP_TAIL_PDF_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define CBET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CBET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cbet_pkg.sv =====
`timescale 1ns / 1ps

package cbet_pkg;

  localparam int LOG_W = 82;
  localparam int LOG_P_W = 7;
  localparam int LOG_OUT_W = LOG_P_W + 32;
  localparam logic [30:0] LOG2E_FRAC = 31'h71547652;

  typedef enum logic [1:0] {
    REGION_CORE = 2'd0,
    REGION_LEFT = 2'd1,
    REGION_RIGHT = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    CFG_CENTRE = 3'd0,
    CFG_SIGMA = 3'd1,
    CFG_LEFT_CUT = 3'd2,
    CFG_LEFT_POWER = 3'd3,
    CFG_RIGHT_CUT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        zero;
    logic [5:0]  k;
    logic [31:0] f;
  } pow2_in_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Fixed-point value of 2^(-2^-j) in Q0.32, built by repeated square roots.
  function automatic logic [31:0] root_const(input int j);
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int i = 1; i <= 32; i++) begin
      if (i <= j) begin
        c = isqrt64({c[31:0], 32'h0});
      end
    end
    return c[31:0];
  endfunction

endpackage

// ===== sv/crystal_ball_exp_tail_pdf.sv =====
`timescale 1ns / 1ps
// A request accepted at a clock edge moves down the pipeline into the output
// register; one request is accepted per cycle while results are taken.
// The depth is set by the 57-stage restoring divider, the 39-stage logarithm
// and the 32-stage power-of-two chain. A skid register after the output lets
// one more result finish while the output stalls. Reset clears all valid flags
// and loads the register defaults; no clearing pass is needed.

`include "crystal_ball_exp_tail_pdf_assert.svh"

module crystal_ball_exp_tail_pdf import cbet_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] density_o,
  output logic [1:0]  region_o
);

  localparam int LAST = 139;

  logic [31:0] centre_q;
  logic [30:0] sigma_q;
  logic [23:0] lcut_q, lpow_q, rcut_q;
  logic [30:0] sgx;
  logic [23:0] a1x, n1x, a2x;
  logic [54:0] lim1_q, lim2_q;

  logic en;
  logic vld_q [0:LAST];
  region_e rg_q [2:LAST];

  logic [31:0] smp_q;
  logic        neg1_q;
  logic [32:0] ad1_q;
  logic [32:0] d1;
  logic [48:0] lhs;
  logic [56:0] dq_q [2:59];
  logic [30:0] rem_q [3:59];

  logic [56:0] w60_q;
  logic [23:0] a60_q;
  logic [27:0] tc60_q;
  logic        bigc60_q, bigc61_q, bigc62_q;
  logic [42:0] p0_q, p1_q, p2_q;
  logic [55:0] ttp_q;
  logic [47:0] aap_q;
  logic [80:0] aw62_q;
  logic [38:0] tt62_q;
  logic [46:0] aa62_q;
  logic [81:0] n63_q;
  logic [47:0] x63_q;
  logic        hx63_q, hx64_q;
  logic [46:0] aa63_q, aa64_q;
  logic [47:0] x64_q;
  logic [54:0] xph_q, xpl_q, aph_q, apl_q;
  logic [78:0] xsum, asum;
  logic [48:0] qcr_q [65:105];
  logic [48:0] qa_q  [65:105];
  logic        hx_q  [65:105];

  logic [LOG_OUT_W-1:0] l1, l0;
  logic [38:0] dl_q;
  logic [42:0] qbh_q;
  logic [43:0] qbl_q;
  logic [62:0] qbsum;
  logic [46:0] qb_q;
  logic [49:0] q106;
  logic        huge106;
  pow2_in_t    pin_q;
  logic [31:0] dens;

  logic        out_valid_q, sk_valid_q;
  logic [31:0] out_dens_q, sk_dens_q;
  region_e     out_rg_q, sk_rg_q;
  logic        take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= '0;
      sigma_q <= 31'd65536;
      lcut_q <= 24'd65536;
      lpow_q <= 24'd131072;
      rcut_q <= 24'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CENTRE: centre_q <= cfg_data_i;
        CFG_SIGMA: sigma_q <= cfg_data_i[30:0];
        CFG_LEFT_CUT: lcut_q <= cfg_data_i[23:0];
        CFG_LEFT_POWER: lpow_q <= cfg_data_i[23:0];
        CFG_RIGHT_CUT: rcut_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign sgx = (sigma_q == '0) ? 31'd1 : sigma_q;
  assign a1x = (lcut_q == '0) ? 24'd1 : lcut_q;
  assign n1x = (lpow_q == '0) ? 24'd1 : lpow_q;
  assign a2x = (rcut_q == '0) ? 24'd1 : rcut_q;

  always_ff @(posedge clk_i) begin
    lim1_q <= a1x * sgx;
    lim2_q <= a2x * sgx;
  end

  assign en = !sk_valid_q;
  assign in_stall_o = sk_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAST; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i <= LAST; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign d1 = {smp_q[31], smp_q} - {centre_q[31], centre_q};
  assign lhs = {ad1_q, 16'h0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      smp_q <= sample_i;
      neg1_q <= d1[32];
      ad1_q <= d1[32] ? 33'(-d1) : d1;
      dq_q[2] <= {ad1_q, 24'h0};
      if (neg1_q && ({6'h0, lhs} >= lim1_q)) begin
        rg_q[2] <= REGION_LEFT;
      end else if (!neg1_q && ({6'h0, lhs} >= lim2_q)) begin
        rg_q[2] <= REGION_RIGHT;
      end else begin
        rg_q[2] <= REGION_CORE;
      end
      for (int i = 3; i <= LAST; i++) begin
        rg_q[i] <= rg_q[i-1];
      end
    end
  end

  for (genvar i = 3; i <= 59; i++) begin : g_div
    logic [30:0] rin;
    logic [31:0] nr;
    logic        ge;
    logic [31:0] diff;
    if (i == 3) begin : g_first
      assign rin = '0;
    end else begin : g_next
      assign rin = rem_q[i-1];
    end
    assign nr = {rin, dq_q[i-1][56]};
    assign ge = nr >= {1'b0, sgx};
    assign diff = nr - {1'b0, sgx};
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[i] <= ge ? diff[30:0] : nr[30:0];
        dq_q[i] <= {dq_q[i-1][55:0], ge};
      end
    end
  end

  assign xsum = {xph_q, 24'h0} + {24'h0, xpl_q};
  assign asum = {aph_q, 24'h0} + {24'h0, apl_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rg_q[59] == REGION_LEFT) begin
        w60_q <= dq_q[59] - {25'h0, a1x, 8'h0};
        a60_q <= a1x;
      end else begin
        w60_q <= dq_q[59] - {26'h0, a2x, 7'h0};
        a60_q <= a2x;
      end
      tc60_q <= dq_q[59][27:0];
      bigc60_q <= |dq_q[59][56:28];

      p0_q <= w60_q[18:0] * a60_q;
      p1_q <= w60_q[37:19] * a60_q;
      p2_q <= w60_q[56:38] * a60_q;
      ttp_q <= tc60_q * tc60_q;
      aap_q <= a1x * a1x;
      bigc61_q <= bigc60_q;

      aw62_q <= {38'h0, p0_q} + {19'h0, p1_q, 19'h0} + {p2_q, 38'h0};
      tt62_q <= ttp_q[55:17];
      aa62_q <= aap_q[47:1];
      bigc62_q <= bigc61_q;

      n63_q <= {1'b0, aw62_q} + {34'h0, n1x, 24'h0};
      if (rg_q[62] == REGION_RIGHT) begin
        x63_q <= aw62_q[55:8];
        hx63_q <= |aw62_q[80:56];
      end else begin
        x63_q <= {9'h0, tt62_q};
        hx63_q <= bigc62_q;
      end
      aa63_q <= aa62_q;

      xph_q <= x63_q[47:24] * LOG2E_FRAC;
      xpl_q <= x63_q[23:0] * LOG2E_FRAC;
      aph_q <= {1'b0, aa63_q[46:24]} * LOG2E_FRAC;
      apl_q <= aa63_q[23:0] * LOG2E_FRAC;
      x64_q <= x63_q;
      aa64_q <= aa63_q;
      hx64_q <= hx63_q;

      qcr_q[65] <= {1'b0, x64_q} + {2'h0, xsum[78:32]};
      qa_q[65] <= {2'h0, aa64_q} + {2'h0, asum[78:32]};
      hx_q[65] <= hx64_q;
      for (int i = 66; i <= 105; i++) begin
        qcr_q[i] <= qcr_q[i-1];
        qa_q[i] <= qa_q[i-1];
        hx_q[i] <= hx_q[i-1];
      end
    end
  end

  cbet_log2 u_log_num (
    .clk_i (clk_i),
    .en_i  (en),
    .val_i (n63_q),
    .log_o (l1)
  );

  cbet_log2 u_log_den (
    .clk_i (clk_i),
    .en_i  (en),
    .val_i ({34'h0, n1x, 24'h0}),
    .log_o (l0)
  );

  assign qbsum = {qbh_q, 20'h0} + {19'h0, qbl_q};

  always_comb begin
    if (rg_q[105] == REGION_LEFT) begin
      q106 = {1'b0, qa_q[105]} + {3'h0, qb_q};
      huge106 = 1'b0;
    end else begin
      q106 = {1'b0, qcr_q[105]};
      huge106 = hx_q[105];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q <= (l1 > l0) ? (l1 - l0) : '0;
      qbh_q <= n1x * dl_q[38:20];
      qbl_q <= n1x * dl_q[19:0];
      qb_q <= qbsum[62:16];
      pin_q.zero <= huge106 || (q106[49:32] > 18'd32);
      pin_q.k <= q106[37:32];
      pin_q.f <= q106[31:0];
    end
  end

  cbet_pow2 u_pow2 (
    .clk_i     (clk_i),
    .en_i      (en),
    .pin_i     (pin_q),
    .density_o (dens)
  );

  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q <= 1'b0;
    end else if (sk_valid_q) begin
      if (take) begin
        sk_valid_q <= 1'b0;
      end
    end else if (vld_q[LAST]) begin
      if (out_valid_q && !take) begin
        sk_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (take) begin
        out_dens_q <= sk_dens_q;
        out_rg_q <= sk_rg_q;
      end
    end else if (vld_q[LAST]) begin
      if (out_valid_q && !take) begin
        sk_dens_q <= dens;
        sk_rg_q <= rg_q[LAST];
      end else begin
        out_dens_q <= dens;
        out_rg_q <= rg_q[LAST];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign density_o = out_dens_q;
  assign region_o = out_rg_q;

  `CBET_ASSERT_IMP(a_skid_behind_out, sk_valid_q, out_valid_q, "skid holds a result ahead of an empty output")
  `CBET_ASSERT_NXT(a_stall_fills_skid, vld_q[LAST] && !sk_valid_q && out_valid_q && out_stall_i, sk_valid_q, "result arriving at a stalled output was dropped")
  `CBET_ASSERT_NXT(a_drain_empties, take && !sk_valid_q && !vld_q[LAST], !out_valid_q, "output stayed valid after its result was taken")
  `CBET_ASSERT_NXT(a_skid_moves, sk_valid_q && take, out_valid_q && !sk_valid_q, "skid result did not move to the output")

endmodule

// ===== sv/cbet_log2.sv =====
`timescale 1ns / 1ps

module cbet_log2 import cbet_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [LOG_W-1:0]     val_i,
  output logic [LOG_OUT_W-1:0] log_o
);

  localparam int NSH = LOG_P_W;

  logic [LOG_W-1:0]   nv_q [NSH];
  logic [LOG_P_W-1:0] lz_q [NSH];
  logic [31:0]        m_q  [32];
  logic [31:0]        fr_q [32];
  logic [LOG_P_W-1:0] p_q  [32];

  for (genvar s = 0; s < NSH; s++) begin : g_norm
    localparam int S = 64 >> s;
    logic [LOG_W-1:0]   vin;
    logic [LOG_P_W-1:0] lzin;
    if (s == 0) begin : g_first
      assign vin = val_i;
      assign lzin = '0;
    end else begin : g_next
      assign vin = nv_q[s-1];
      assign lzin = lz_q[s-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (vin[LOG_W-1 -: S] == '0) begin
          nv_q[s] <= vin << S;
          lz_q[s] <= lzin | LOG_P_W'(S);
        end else begin
          nv_q[s] <= vin;
          lz_q[s] <= lzin;
        end
      end
    end
  end

  for (genvar i = 0; i < 32; i++) begin : g_sq
    logic [31:0]        min;
    logic [31:0]        fin;
    logic [LOG_P_W-1:0] pin;
    logic [63:0]        sq;
    if (i == 0) begin : g_first
      assign min = nv_q[NSH-1][LOG_W-1 -: 32];
      assign fin = '0;
      assign pin = LOG_P_W'(LOG_W - 1) - lz_q[NSH-1];
    end else begin : g_next
      assign min = m_q[i-1];
      assign fin = fr_q[i-1];
      assign pin = p_q[i-1];
    end
    assign sq = min * min;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i] <= sq[63] ? sq[63:32] : sq[62:31];
        fr_q[i] <= {fin[30:0], sq[63]};
        p_q[i] <= pin;
      end
    end
  end

  assign log_o = {p_q[31], fr_q[31]};

endmodule

// ===== sv/cbet_pow2.sv =====
`timescale 1ns / 1ps

module cbet_pow2 import cbet_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  pow2_in_t    pin_i,
  output logic [31:0] density_o
);

  logic [32:0] m_q  [1:32];
  pow2_in_t    st_q [1:32];
  logic [31:0] dens_q;
  logic [32:0] sh;

  for (genvar j = 1; j <= 32; j++) begin : g_step
    localparam logic [31:0] CJ = root_const(j);
    logic [32:0] min;
    pow2_in_t    sin;
    logic [64:0] prod;
    if (j == 1) begin : g_first
      assign min = 33'h1_0000_0000;
      assign sin = pin_i;
    end else begin : g_next
      assign min = m_q[j-1];
      assign sin = st_q[j-1];
    end
    assign prod = min * CJ;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[j] <= sin.f[32-j] ? prod[64:32] : min;
        st_q[j] <= sin;
      end
    end
  end

  assign sh = m_q[32] >> st_q[32].k;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (st_q[32].zero) begin
        dens_q <= '0;
      end else if (sh[32]) begin
        dens_q <= '1;
      end else begin
        dens_q <= sh[31:0];
      end
    end
  end

  assign density_o = dens_q;

endmodule

// ===== verif/tb_crystal_ball_exp_tail_pdf.sv =====
`timescale 1ns / 1ps

module tb_crystal_ball_exp_tail_pdf;
  import cbet_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_PER_PHASE = 80;
  localparam logic [63:0] LOG2E_Q32 = 64'h1_7154_7652;
  localparam logic [2:0] CFG_SPARE_IDX = 3'd6;
  localparam logic [2:0] CFG_TOP_IDX = 3'd7;

  typedef struct packed {
    logic [31:0] density;
    region_e     region;
  } shape_t;

  typedef struct {
    logic [31:0] sample;
    logic        typed;
    logic [31:0] density;
    region_e     region;
  } probe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] density_o;
  logic [1:0]  region_o;

  logic [31:0] cur_centre;
  logic [30:0] cur_sigma;
  logic [23:0] cur_lcut, cur_lpow, cur_rcut;
  logic [63:0] half_root[1:32];

  shape_t shapes_due[$];
  int errors = 0;
  int samples_sent = 0;
  int shapes_checked = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_tick = 0;
  logic hold_long = 1'b0;
  int region_seen[3] = '{0, 0, 0};

  crystal_ball_exp_tail_pdf DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .sample_i, .out_valid_o, .out_stall_i,
    .density_o, .region_o
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem, root, bitv;
    rem = v;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem && bitv != 0) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
    logic [127:0] prod;
    prod = {64'b0, a} * {64'b0, b};
    prod = prod >> sh;
    if (prod[127:64] != 0) return '1;
    return prod[63:0];
  endfunction

  function automatic logic [63:0] log2_fixed(input logic [127:0] v);
    int p;
    logic [63:0] m, s, frac;
    p = 0;
    for (int i = 0; i < 128; i++) if (v[i]) p = i;
    if (p >= 31) m = 64'(v >> (p - 31)) & 64'hFFFF_FFFF;
    else m = 64'(v << (31 - p));
    frac = '0;
    for (int i = 0; i < 32; i++) begin
      s = m * m;
      frac = frac << 1;
      if (s[63]) begin
        frac[0] = 1'b1;
        m = s >> 32;
      end else begin
        m = s >> 31;
      end
    end
    return (64'(p) << 32) | frac;
  endfunction

  function automatic logic [31:0] exp2_neg(input logic [63:0] q);
    logic [63:0] k, m;
    logic [127:0] prod;
    k = q >> 32;
    if (k > 32) return '0;
    m = 64'h1_0000_0000;
    for (int j = 1; j <= 32; j++) begin
      if (q[32 - j]) begin
        prod = {64'b0, m} * {64'b0, half_root[j]};
        m = prod[95:32];
      end
    end
    m = m >> k;
    return (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
  endfunction

  function automatic shape_t shape_of(input logic [31:0] sample);
    logic [63:0] sg, a1, n1, a2, ad, t, lhs, w, dn, l1, l0, dl, qa, qb, q;
    logic signed [63:0] d;
    logic [127:0] nsum;
    logic neg;
    shape_t r;
    sg = (cur_sigma == 0) ? 64'd1 : 64'(cur_sigma);
    a1 = (cur_lcut == 0) ? 64'd1 : 64'(cur_lcut);
    n1 = (cur_lpow == 0) ? 64'd1 : 64'(cur_lpow);
    a2 = (cur_rcut == 0) ? 64'd1 : 64'(cur_rcut);
    d = 64'($signed(sample)) - 64'($signed(cur_centre));
    neg = d < 0;
    ad = neg ? 64'(-d) : 64'(d);
    t = (ad << 24) / sg;
    lhs = ad << 16;
    if (neg && lhs >= a1 * sg) begin
      w = t - (a1 << 8);
      dn = n1 << 24;
      nsum = {64'b0, w} * {64'b0, a1} + {64'b0, dn};
      l1 = log2_fixed(nsum);
      l0 = log2_fixed({64'b0, dn});
      dl = (l1 > l0) ? l1 - l0 : 64'd0;
      qa = mul_shift(mul_shift(a1, a1, 1), LOG2E_Q32, 32);
      qb = mul_shift(n1, dl, 16);
      q = (qa > ~qb) ? '1 : qa + qb;
      r.region = REGION_LEFT;
    end else if (!neg && lhs >= a2 * sg) begin
      q = mul_shift(mul_shift(a2, t - (a2 << 7), 8), LOG2E_Q32, 32);
      r.region = REGION_RIGHT;
    end else begin
      q = mul_shift(mul_shift(t, t, 17), LOG2E_Q32, 32);
      r.region = REGION_CORE;
    end
    r.density = exp2_neg(q);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch %s: expected %h, got %h (result %0d)", what, want, got,
             shapes_checked);
    errors++;
  endtask

  always @(posedge clk_i) begin
    shape_t want;
    if (out_valid_o && !out_stall_i) begin
      if (shapes_due.size() == 0) begin
        report_mismatch("unexpected result", '0, density_o);
      end else begin
        want = shapes_due.pop_front();
        if (density_o !== want.density) report_mismatch("density", want.density, density_o);
        if (region_o !== want.region) report_mismatch("region", want.region, region_o);
        if (region_o < 3) region_seen[region_o]++;
      end
      shapes_checked++;
    end
    rx_tick <= rx_tick + 1;
    case ((rx_tick >> 6) % 4)
      0: out_stall_i <= hold_long;
      1: out_stall_i <= hold_long || ($urandom_range(0, 1) == 1);
      2: out_stall_i <= hold_long || (rx_tick % 7 < 3);
      default: out_stall_i <= hold_long || ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
    $display("tb_crystal_ball_exp_tail_pdf: done, errors");
    $finish;
  end

  initial begin
    while (samples_sent < 60) @(posedge clk_i);
    hold_long = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_long = 1'b0;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
    case (idx)
      CFG_CENTRE: cur_centre = value;
      CFG_SIGMA: cur_sigma = value[30:0];
      CFG_LEFT_CUT: cur_lcut = value[23:0];
      CFG_LEFT_POWER: cur_lpow = value[23:0];
      CFG_RIGHT_CUT: cur_rcut = value[23:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] centre, input logic [31:0] sigma,
                           input logic [31:0] lcut, input logic [31:0] lpow,
                           input logic [31:0] rcut);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shapes_due.size() != 0) @(posedge clk_i);
    write_reg(CFG_CENTRE, centre);
    write_reg(CFG_SIGMA, sigma);
    write_reg(CFG_LEFT_CUT, lcut);
    write_reg(CFG_LEFT_POWER, lpow);
    write_reg(CFG_RIGHT_CUT, rcut);
  endtask

  task automatic send_sample(input logic [31:0] value, input logic typed,
                             input shape_t typed_shape);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 15);
    end
    in_valid_i <= 1'b1;
    sample_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shapes_due.push_back(typed ? typed_shape : shape_of(value));
    samples_sent++;
    burst_left--;
  endtask

  task automatic random_samples(input int count);
    logic [63:0] sg;
    logic signed [63:0] off;
    logic [31:0] v;
    sg = (cur_sigma == 0) ? 64'd1 : 64'(cur_sigma);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        v = $urandom;
      end else begin
        off = ($signed(64'($urandom_range(0, 16000))) - 64'sd8000) * $signed(sg)
              / 64'sd1000;
        v = cur_centre + off[31:0];
      end
      send_sample(v, 1'b0, '0);
    end
  endtask

  probe_t probes[] = '{
    '{32'h0000_0000, 1'b1, 32'hFFFF_FFFF, REGION_CORE},
    '{32'h7FFF_FFFF, 1'b1, 32'h0000_0000, REGION_RIGHT},
    '{32'h8000_0000, 1'b0, '0, REGION_CORE},
    '{32'h0000_0001, 1'b0, '0, REGION_CORE},
    '{32'hFFFF_FFFF, 1'b0, '0, REGION_CORE},
    '{32'h0000_FFFF, 1'b0, '0, REGION_CORE},
    '{32'h0001_0000, 1'b0, '0, REGION_CORE},
    '{32'hFFFF_0001, 1'b0, '0, REGION_CORE},
    '{32'hFFFF_0000, 1'b0, '0, REGION_CORE},
    '{32'h0002_8000, 1'b0, '0, REGION_CORE},
    '{32'hFFFC_0000, 1'b0, '0, REGION_CORE},
    '{32'h0010_0000, 1'b0, '0, REGION_CORE},
    '{32'hFF00_0000, 1'b0, '0, REGION_CORE},
    '{32'h5555_5555, 1'b0, '0, REGION_CORE},
    '{32'hAAAA_AAAA, 1'b0, '0, REGION_CORE}
  };

  initial begin
    logic [63:0] c;
    shape_t typed_shape;
    c = 64'h8000_0000;
    for (int j = 1; j <= 32; j++) begin
      c = int_sqrt(c << 32);
      half_root[j] = c;
    end
    cur_centre = 32'd0;
    cur_sigma = 31'd65536;
    cur_lcut = 24'd65536;
    cur_lpow = 24'd131072;
    cur_rcut = 24'd65536;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      typed_shape.density = probes[i].density;
      typed_shape.region = probes[i].region;
      send_sample(probes[i].sample, probes[i].typed, typed_shape);
    end
    random_samples(3 * RANDOM_PER_PHASE);

    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF);
    random_samples(RANDOM_PER_PHASE);

    configure(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
    write_reg(CFG_SPARE_IDX, $urandom);
    write_reg(CFG_TOP_IDX, $urandom);
    send_sample(32'h7FFF_FFFF, 1'b0, '0);
    send_sample(32'h8000_0000, 1'b0, '0);
    random_samples(RANDOM_PER_PHASE);

    configure(32'h0001_2345, 32'h0000_8000, 32'h01_8000, 32'h03_0000, 32'h02_0000);
    random_samples(RANDOM_PER_PHASE);

    configure(32'hFFFB_0000, 32'h0003_0000, 32'h00_8000, 32'h10_0000, 32'h00_4000);
    random_samples(RANDOM_PER_PHASE);

    configure($urandom, {1'b0, 31'($urandom_range(1, 32'h0100_0000))},
              $urandom_range(1, 24'h08_0000), $urandom_range(1, 24'hFF_FFFF),
              $urandom_range(1, 24'h08_0000));
    random_samples(RANDOM_PER_PHASE);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shapes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d samples, %0d results checked, %0d register writes",
             samples_sent, shapes_checked, reg_writes);
    $display("regions seen: core %0d, left tail %0d, right tail %0d",
             region_seen[0], region_seen[1], region_seen[2]);
    if (errors == 0) begin
      $display("tb_crystal_ball_exp_tail_pdf: done, clean");
    end else begin
      $display("tb_crystal_ball_exp_tail_pdf: done, errors");
    end
    $finish;
  end

endmodule
